### hdl/zsaf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zsaf_pkg
// Shared constants and helpers for the stored-mode archive framer.
// ----------------------------------------------------------------------------
package zsaf_pkg;
    localparam int MAX_FILES_D = 16;
    localparam int MAX_NAME_D  = 32;
    localparam int MAX_ALIGN_D = 32;

    localparam logic [2:0] CMD_START = 3'd0;
    localparam logic [2:0] CMD_DATA  = 3'd1;
    localparam logic [2:0] CMD_END   = 3'd2;
    localparam logic [2:0] CMD_DIR   = 3'd3;
    localparam logic [2:0] CMD_DEND  = 3'd4;

    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_NAME    = 2'd1;
    localparam logic [1:0] PH_CONTENT = 2'd2;

    localparam logic [31:0] CRC_POLY = 32'hedb88320;

    // one bit step of the reflected CRC
    function automatic logic [31:0] crc_bit(input logic [31:0] c);
        crc_bit = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    endfunction
endpackage

### hdl/zsaf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zsaf_ram
// Generic single-port-write RAM with registered read.
// ----------------------------------------------------------------------------
module zsaf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### hdl/zip_store_archive_framer.sv
`timescale 1ns / 1ps
// Flow: a word's first byte is registered from S_EMIT (S_NAME or S_PAD for a
// directory name step); a directory step first reads the table in S_RD, a content
// data_byte first runs the bit-serial CRC in S_CRC, and a start_file first passes
// S_MOD (which runs the remainder only with alignment) and S_OUT. Then one byte per
// cycle while i_stall is low; stored directory name bytes each pass S_NAME and S_RD2.
// The next word is accepted the cycle after the last byte is taken, if there is one.
// Reset: synchronous active-low; control state cleared, memories not.
// ----------------------------------------------------------------------------
// zip_store_archive_framer
// Sequencer emitting a stored ZIP stream byte by byte from a shared field mux.
// ----------------------------------------------------------------------------
module zip_store_archive_framer #(
    parameter int MAX_FILES = zsaf_pkg::MAX_FILES_D,
    parameter int MAX_NAME  = zsaf_pkg::MAX_NAME_D,
    parameter int MAX_ALIGN = zsaf_pkg::MAX_ALIGN_D
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_command,
    input  logic [7:0]  i_data_byte,
    input  logic [31:0] i_modified,
    input  logic [5:0]  i_name_length,
    input  logic [5:0]  i_alignment,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_last,
    output logic        o_error
);
    import zsaf_pkg::*;

    localparam int FW = $clog2(MAX_FILES + 1);
    localparam int FA = (MAX_FILES > 1) ? $clog2(MAX_FILES) : 1;
    localparam int SA = $clog2(MAX_FILES * MAX_NAME) > 0 ? $clog2(MAX_FILES * MAX_NAME) : 1;
    localparam int TW = 128 + 6 + 6;
    localparam logic [FW-1:0] FMAX = FW'(MAX_FILES);
    localparam logic [5:0] NMAX = 6'(MAX_NAME);
    localparam logic [5:0] AMAX = 6'(MAX_ALIGN);

    // sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MOD   = 4'd1;  // padding remainder, one bit per cycle
    localparam logic [3:0] S_EMIT  = 4'd2;  // emit r_len bytes of a record
    localparam logic [3:0] S_PAD   = 4'd3;  // zero padding
    localparam logic [3:0] S_CRC   = 4'd4;
    localparam logic [3:0] S_RD    = 4'd5;  // memory read latency
    localparam logic [3:0] S_NAME  = 4'd6;  // stored name bytes
    localparam logic [3:0] S_OUT   = 4'd7;  // start_file bookkeeping and table write
    localparam logic [3:0] S_RD2   = 4'd8;

    localparam logic [2:0] K_LOCAL = 3'd0;
    localparam logic [2:0] K_DESC  = 3'd1;
    localparam logic [2:0] K_CDIR  = 3'd2;
    localparam logic [2:0] K_EREC  = 3'd3;
    localparam logic [2:0] K_ONE   = 3'd4;  // single byte in r_byte
    localparam logic [2:0] K_ERR   = 3'd5;

    logic [3:0]    r_st;
    logic [2:0]    r_kind;
    logic [5:0]    r_idx, r_len;
    logic [5:0]    r_pcnt;
    logic [7:0]    r_byte;
    logic [2:0]    r_bit;
    logic          r_tail;        // padding follows the record
    logic [31:0]   r_arch, r_crc, r_flen, r_doff, r_dsize, r_rem;
    logic [5:0]    r_racc;
    logic [4:0]    r_mcnt;
    logic [FW-1:0] r_fcnt, r_didx;
    logic          r_dhalf;
    logic [5:0]    r_dnl, r_dpad; // name length and padding of the directory entry
    logic [1:0]    r_ph;
    logic [5:0]    r_nidx;
    logic [5:0]    r_nl, r_al, r_pad;
    logic [31:0]   r_offs, r_mod;
    logic          r_ov;
    logic [7:0]    r_ob;
    logic          r_ol, r_oe;

    // file table: {offset, modified, crc, length, name_len, pad}
    logic          t_we;
    logic [FA-1:0] t_wa, t_ra;
    logic [TW-1:0] t_wd, t_rd;
    logic          s_we;
    logic [SA-1:0] s_wa, s_ra;
    logic [7:0]    s_rd;

    zsaf_ram #(.WIDTH(TW), .DEPTH(MAX_FILES)) u_tab (
        .i_clk(i_clk), .i_we(t_we), .i_waddr(t_wa), .i_wdata(t_wd),
        .i_raddr(t_ra), .o_rdata(t_rd));
    zsaf_ram #(.WIDTH(8), .DEPTH(MAX_FILES * MAX_NAME)) u_names (
        .i_clk(i_clk), .i_we(s_we), .i_waddr(s_wa), .i_wdata(r_byte),
        .i_raddr(s_ra), .o_rdata(s_rd));

    wire [FA-1:0] w_slot = FA'(r_fcnt - 1'b1);
    // directory index moves on in S_RD, so later name reads look one entry back
    wire [FW-1:0] w_nsel = (r_st == S_RD) ? r_didx : r_didx - 1'b1;
    wire [31:0] e_off = t_rd[139:108];
    wire [31:0] e_mod = t_rd[107:76];
    wire [31:0] e_crc = t_rd[75:44];
    wire [31:0] e_len = t_rd[43:12];
    wire [5:0]  e_nl  = t_rd[11:6];
    wire [5:0]  e_pad = t_rd[5:0];

    assign t_ra = FA'(r_didx);
    assign s_ra = SA'(w_nsel * MAX_NAME) + SA'(r_pcnt);

    // restoring remainder step
    wire [6:0] w_mtry = {r_racc, r_rem[31]};
    wire [5:0] w_racc = (w_mtry >= {1'b0, r_al}) ? 6'(w_mtry - {1'b0, r_al}) : w_mtry[5:0];

    // record byte selector: the shared field mux
    logic [7:0] w_rb;
    logic [31:0] w32;
    always_comb begin
        w_rb = 8'h00;
        w32  = 32'h0;
        unique case (r_kind)
            K_LOCAL: begin
                priority if (r_idx < 6'd4) w_rb = (r_idx == 0) ? 8'h50 : (r_idx == 1) ? 8'h4b
                                           : (r_idx == 2) ? 8'h03 : 8'h04;
                else if (r_idx == 6'd4) w_rb = 8'h14;
                else if (r_idx == 6'd6) w_rb = 8'h08;
                else if (r_idx >= 6'd10 && r_idx < 6'd14) begin
                    w32 = r_mod >> {r_idx[1:0] - 2'd2, 3'b000};
                    w_rb = w32[7:0];
                end
                else if (r_idx == 6'd26) w_rb = {2'b00, r_nl};
                else if (r_idx == 6'd28) w_rb = {2'b00, r_pad};
                else w_rb = 8'h00;
            end
            K_DESC: begin
                priority if (r_idx < 6'd4) w_rb = (r_idx == 0) ? 8'h50 : (r_idx == 1) ? 8'h4b
                                           : (r_idx == 2) ? 8'h07 : 8'h08;
                else begin
                    w32 = (r_idx < 6'd8) ? ~r_crc : r_flen;
                    w_rb = w32[8*r_idx[1:0] +: 8];
                end
            end
            K_CDIR: begin
                priority if (r_idx < 6'd4) w_rb = (r_idx == 0) ? 8'h50 : (r_idx == 1) ? 8'h4b
                                           : (r_idx == 2) ? 8'h01 : 8'h02;
                else if (r_idx == 6'd4 || r_idx == 6'd6) w_rb = 8'h14;
                else if (r_idx == 6'd8) w_rb = 8'h08;
                else if (r_idx >= 6'd12 && r_idx < 6'd28) begin
                    w32 = (r_idx < 6'd16) ? e_mod : (r_idx < 6'd20) ? e_crc : e_len;
                    w_rb = w32[8*r_idx[1:0] +: 8];
                end
                else if (r_idx == 6'd28) w_rb = {2'b00, e_nl};
                else if (r_idx == 6'd30) w_rb = {2'b00, e_pad};
                else if (r_idx >= 6'd42) begin
                    w32 = e_off >> {r_idx[1:0] - 2'd2, 3'b000};
                    w_rb = w32[7:0];
                end
                else w_rb = 8'h00;
            end
            K_EREC: begin
                priority if (r_idx < 6'd4) w_rb = (r_idx == 0) ? 8'h50 : (r_idx == 1) ? 8'h4b
                                           : (r_idx == 2) ? 8'h05 : 8'h06;
                else if (r_idx >= 6'd8 && r_idx < 6'd12)
                    w_rb = 8'(({{(32-FW){1'b0}}, r_fcnt}) >> {r_idx[0], 3'b000});
                else if (r_idx >= 6'd12 && r_idx < 6'd20) begin
                    w32 = (r_idx < 6'd16) ? r_dsize : r_doff;
                    w_rb = w32[8*r_idx[1:0] +: 8];
                end
                else w_rb = 8'h00;
            end
            K_ONE:   w_rb = r_byte;
            K_ERR:   w_rb = 8'h00;
            default: w_rb = 8'h00;
        endcase
    end

    wire w_free = !r_ov || !i_stall;
    wire w_acc  = i_valid && !o_stall;
    assign o_stall = (r_st != S_IDLE) || r_ov;
    assign o_valid = r_ov;
    assign o_out_byte = r_ob;
    assign o_last = r_ol;
    assign o_error = r_oe;

    wire [5:0] w_nl = (i_name_length > NMAX) ? NMAX : i_name_length;
    wire [5:0] w_al = (i_alignment > AMAX) ? AMAX : i_alignment;

    // table writes are issued from a registered request
    logic          r_twe;
    logic [FA-1:0] r_twa;
    logic [TW-1:0] r_twd;
    logic          r_swe;
    logic [SA-1:0] r_swa;
    assign t_we = r_twe;
    assign s_we = r_swe;
    assign s_wa = r_swa;
    assign t_wa = r_twa;
    assign t_wd = r_twd;

    wire        w_emit = (r_st == S_EMIT || r_st == S_PAD || r_st == S_NAME) && w_free;
    logic [7:0] w_ebyte;
    always_comb begin
        unique case (r_st)
            S_NAME:  w_ebyte = s_rd;
            S_PAD:   w_ebyte = 8'h00;
            default: w_ebyte = w_rb;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_ov <= 1'b0; r_arch <= '0; r_fcnt <= '0; r_ph <= PH_IDLE;
            r_crc <= '1; r_flen <= '0; r_nidx <= '0; r_didx <= '0; r_dhalf <= 1'b0;
            r_doff <= '0; r_dsize <= '0; r_twe <= 1'b0; r_swe <= 1'b0;
        end else begin
            r_twe <= 1'b0;
            r_swe <= 1'b0;
            if (r_ov && !i_stall) r_ov <= 1'b0;
            unique case (r_st)
                S_IDLE: if (w_acc) begin
                    r_idx <= '0; r_tail <= 1'b0; r_pcnt <= '0; r_oe <= 1'b0;
                    r_byte <= i_data_byte;
                    unique case (i_command)
                        CMD_START: if (r_fcnt >= FMAX) begin
                            r_kind <= K_ERR; r_len <= 6'd1; r_st <= S_EMIT; r_oe <= 1'b1;
                        end else begin
                            r_nl <= w_nl; r_al <= w_al; r_mod <= i_modified;
                            r_offs <= r_arch; r_rem <= r_arch + 32'd30 + 32'(w_nl);
                            r_racc <= '0; r_mcnt <= '0;
                            r_st <= S_MOD;
                        end
                        CMD_DATA: if (r_ph != PH_IDLE && r_fcnt != 0) begin
                            r_kind <= K_ONE; r_len <= 6'd1; r_arch <= r_arch + 32'd1;
                            if (r_ph == PH_NAME) begin
                                if (r_nidx < NMAX) begin
                                    r_swe <= 1'b1;
                                    r_swa <= SA'(w_slot * MAX_NAME) + SA'(r_nidx);
                                end
                                r_nidx <= r_nidx + 6'd1;
                                if (r_nidx + 6'd1 >= r_nl) begin
                                    r_ph <= PH_CONTENT; r_tail <= (r_pad != 0);
                                    r_arch <= r_arch + 32'd1 + 32'(r_pad);
                                end
                                r_st <= S_EMIT;
                            end else begin
                                r_crc <= r_crc ^ {24'h0, i_data_byte};
                                r_flen <= r_flen + 32'd1; r_bit <= '0; r_st <= S_CRC;
                            end
                        end
                        CMD_END: if (r_ph == PH_CONTENT) begin
                            r_kind <= K_DESC; r_len <= 6'd16; r_st <= S_EMIT;
                            r_arch <= r_arch + 32'd16; r_ph <= PH_IDLE;
                        end
                        CMD_DIR: begin
                            if (r_didx == 0 && !r_dhalf) begin
                                r_doff <= r_arch; r_dsize <= '0;
                            end
                            if (r_didx < r_fcnt) r_st <= S_RD;
                        end
                        CMD_DEND: begin
                            r_kind <= K_EREC; r_len <= 6'd22; r_st <= S_EMIT;
                            r_arch <= r_arch + 32'd22;
                        end
                        default: ;
                    endcase
                end
                S_MOD: begin
                    // remainder of the content offset by the alignment, MSB first
                    if (r_al == 0) begin
                        r_pad <= '0; r_st <= S_OUT;
                    end else begin
                        r_racc <= w_racc;
                        r_rem <= r_rem << 1;
                        r_mcnt <= r_mcnt + 5'd1;
                        if (r_mcnt == 5'd31) begin
                            r_pad <= (w_racc == 6'd0) ? 6'd0 : r_al - w_racc;
                            r_st <= S_OUT;
                        end
                    end
                end
                S_OUT: begin
                    // start_file bookkeeping once padding is known
                    r_twe <= 1'b1; r_twa <= FA'(r_fcnt);
                    r_twd <= {r_offs, r_mod, 32'h0, 32'h0, r_nl, r_pad};
                    r_fcnt <= r_fcnt + 1'b1;
                    r_crc <= '1; r_flen <= '0; r_nidx <= '0;
                    r_kind <= K_LOCAL; r_len <= 6'd30;
                    if (r_nl == 0) begin
                        r_ph <= PH_CONTENT; r_tail <= (r_pad != 0);
                        r_arch <= r_arch + 32'd30 + 32'(r_pad);
                    end else begin
                        r_ph <= PH_NAME; r_arch <= r_arch + 32'd30;
                    end
                    r_st <= S_EMIT;
                end
                S_CRC: begin
                    r_crc <= crc_bit(r_crc);
                    r_bit <= r_bit + 3'd1;
                    if (r_bit == 3'd7) begin
                        r_twe <= 1'b1; r_twa <= w_slot;
                        r_twd <= {r_offs, r_mod, ~crc_bit(r_crc), r_flen, r_nl, r_pad};
                        r_st <= S_EMIT;
                    end
                end
                S_RD: begin
                    // table entry is valid now; choose half
                    if (!r_dhalf) begin
                        r_kind <= K_CDIR; r_len <= 6'd46; r_st <= S_EMIT;
                        r_dhalf <= 1'b1;
                        r_dsize <= r_dsize + 32'd46; r_arch <= r_arch + 32'd46;
                    end else begin
                        r_dhalf <= 1'b0; r_didx <= r_didx + 1'b1;
                        r_dnl <= (e_nl > NMAX) ? NMAX : e_nl; r_dpad <= e_pad;
                        r_dsize <= r_dsize + 32'(e_nl) + 32'(e_pad);
                        r_arch <= r_arch + 32'(e_nl) + 32'(e_pad);
                        r_pcnt <= '0;
                        if (e_nl != 0) r_st <= S_NAME;
                        else if (e_pad != 0) begin r_len <= e_pad; r_st <= S_PAD; end
                        else r_st <= S_IDLE;
                    end
                end
                default: ;
            endcase
            if (w_emit) begin
                r_ov <= 1'b1; r_ob <= w_ebyte; r_ol <= 1'b0;
                unique case (r_st)
                    S_EMIT: begin
                        r_idx <= r_idx + 6'd1;
                        if (r_idx + 6'd1 == r_len) begin
                            if (r_tail) begin
                                r_st <= S_PAD; r_len <= r_pad; r_pcnt <= '0;
                            end else begin
                                r_ol <= 1'b1; r_st <= S_IDLE;
                            end
                        end
                    end
                    S_PAD: begin
                        r_pcnt <= r_pcnt + 6'd1;
                        if (r_pcnt + 6'd1 == r_len) begin r_ol <= 1'b1; r_st <= S_IDLE; end
                    end
                    default: begin
                        // S_NAME: advance the name address, then wait in S_RD2 for the registered read
                        if (r_pcnt + 6'd1 == r_dnl) begin
                            r_pcnt <= '0;
                            if (r_dpad != 0) begin r_len <= r_dpad; r_st <= S_PAD; end
                            else begin r_ol <= 1'b1; r_st <= S_IDLE; end
                        end else begin
                            r_pcnt <= r_pcnt + 6'd1;
                            r_st <= S_RD2;
                        end
                    end
                endcase
            end
            if (r_st == S_RD2) r_st <= S_NAME;
        end
    end
endmodule

### hdl/zsaf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zsaf_checker
// Port-level checks on the framer's output stream.
// ----------------------------------------------------------------------------
module zsaf_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_out_byte,
    input logic       o_last,
    input logic       o_error
);
    // a stalled output word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_byte) && $stable(o_last))
        else $error("output word changed under stall");
    // an error word is a single last byte of zero
    a_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_error |-> o_last && o_out_byte == 8'h00)
        else $error("malformed error word");
    // no input taken while output is pending
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input accepted with output pending");
endmodule

bind zip_store_archive_framer zsaf_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
    .o_valid(o_valid), .i_stall(i_stall), .o_out_byte(o_out_byte),
    .o_last(o_last), .o_error(o_error));

### tb/zip_store_archive_framer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zip_store_archive_framer_tb
// Drives a directed run of commands and then random files until the table of
// sixteen is full, with names, padding, content and noise, then the table-full
// rejects, the central directory and the end record. Every emitted byte is checked
// against an in-bench model of the archive stream under random idling.
// ----------------------------------------------------------------------------
module zip_store_archive_framer_tb;
    import zsaf_pkg::*;

    localparam logic [2:0] CMD_RSVD = 3'd5;

    typedef struct {
        logic [7:0] b;
        logic       last;
        logic       err;
    } t_zip_byte;

    typedef struct {
        logic [2:0]  cmd;
        logic [7:0]  data;
        logic [31:0] modified;
        logic [5:0]  nl;
        logic [5:0]  al;
        int          first;   // typed first byte, -1 when left to the model
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [2:0]  i_command = CMD_START;
    logic [7:0]  i_data_byte = '0;
    logic [31:0] i_modified = '0;
    logic [5:0]  i_name_length = '0;
    logic [5:0]  i_alignment = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [7:0]  o_out_byte;
    logic        o_last;
    logic        o_error;

    zip_store_archive_framer dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // archive model state
    logic [31:0] arch_len, cur_crc, file_len, dir_off, dir_size;
    int          n_files, name_idx, dir_idx, dir_half;
    logic [1:0]  ph;
    logic [31:0] ent_off[MAX_FILES_D], ent_mod[MAX_FILES_D];
    logic [31:0] ent_crc[MAX_FILES_D], ent_len[MAX_FILES_D];
    int          ent_nl[MAX_FILES_D], ent_pad[MAX_FILES_D];
    logic [7:0]  names[MAX_FILES_D * MAX_NAME_D];

    t_zip_byte   stream_q[$];
    int          n_out;
    bit          failed = 0;

    function automatic void emit(logic [7:0] v);
        stream_q.push_back('{v, 1'b0, 1'b0});
        n_out++;
    endfunction

    function automatic void emit16(logic [15:0] v);
        emit(v[7:0]); emit(v[15:8]);
    endfunction

    function automatic void emit32(logic [31:0] v);
        emit16(v[15:0]); emit16(v[31:16]);
    endfunction

    function automatic void emit_sig(logic [7:0] a, logic [7:0] c);
        emit(8'h50); emit(8'h4b); emit(a); emit(c);
    endfunction

    function automatic logic [31:0] crc_update(logic [31:0] c, logic [7:0] v);
        c ^= {24'd0, v};
        for (int k = 0; k < 8; k++)
            c = c[0] ? ((c >> 1) ^ 32'hedb88320) : (c >> 1);
        return c;
    endfunction

    // works out the archive bytes that one word produces
    function automatic void predict_archive(logic [2:0] cmd, logic [7:0] d,
                                            logic [31:0] m, logic [5:0] nl_in,
                                            logic [5:0] al_in);
        int nl, al, pad, r, s;
        n_out = 0;
        case (cmd)
            CMD_START: begin
                if (n_files >= MAX_FILES_D) begin
                    stream_q.push_back('{8'h00, 1'b0, 1'b1});
                    n_out = 1;
                end else begin
                    nl = (nl_in > MAX_NAME_D) ? MAX_NAME_D : nl_in;
                    al = (al_in > MAX_ALIGN_D) ? MAX_ALIGN_D : al_in;
                    pad = 0;
                    if (al > 0) begin
                        r = (arch_len + 32'd30 + nl) % al;
                        pad = r ? al - r : 0;
                    end
                    s = n_files;
                    ent_off[s] = arch_len; ent_mod[s] = m;
                    ent_crc[s] = '0; ent_len[s] = '0;
                    ent_nl[s] = nl; ent_pad[s] = pad;
                    n_files++;
                    emit_sig(8'h03, 8'h04);
                    emit16(16'h14); emit16(16'd8); emit16(16'd0);
                    emit32(m);
                    emit32('0); emit32('0); emit32('0);
                    emit16(16'(nl)); emit16(16'(pad));
                    arch_len += 32'd30;
                    cur_crc = '1; file_len = '0; name_idx = 0;
                    if (nl == 0) begin
                        repeat (pad) emit(8'h00);
                        arch_len += pad;
                        ph = PH_CONTENT;
                    end else begin
                        ph = PH_NAME;
                    end
                end
            end
            CMD_DATA: begin
                if (ph != PH_IDLE && n_files > 0) begin
                    s = n_files - 1;
                    emit(d);
                    arch_len += 1;
                    if (ph == PH_NAME) begin
                        if (name_idx < MAX_NAME_D) names[s * MAX_NAME_D + name_idx] = d;
                        name_idx++;
                        if (name_idx >= ent_nl[s]) begin
                            repeat (ent_pad[s]) emit(8'h00);
                            arch_len += ent_pad[s];
                            ph = PH_CONTENT;
                        end
                    end else begin
                        cur_crc = crc_update(cur_crc, d);
                        file_len += 1;
                        ent_crc[s] = ~cur_crc;
                        ent_len[s] = file_len;
                    end
                end
            end
            CMD_END: begin
                if (ph == PH_CONTENT) begin
                    emit_sig(8'h07, 8'h08);
                    emit32(~cur_crc); emit32(file_len); emit32(file_len);
                    arch_len += 32'd16;
                    ph = PH_IDLE;
                end
            end
            CMD_DIR: begin
                if (dir_idx == 0 && dir_half == 0) begin
                    dir_off = arch_len;
                    dir_size = '0;
                end
                if (dir_idx < n_files) begin
                    s = dir_idx;
                    if (dir_half == 0) begin
                        emit_sig(8'h01, 8'h02);
                        emit16(16'h14); emit16(16'h14); emit16(16'd8); emit16(16'd0);
                        emit32(ent_mod[s]); emit32(ent_crc[s]);
                        emit32(ent_len[s]); emit32(ent_len[s]);
                        emit16(16'(ent_nl[s])); emit16(16'(ent_pad[s]));
                        emit16(16'd0); emit16(16'd0); emit16(16'd0);
                        emit32('0); emit32(ent_off[s]);
                        dir_half = 1;
                    end else begin
                        for (int k = 0; k < ent_nl[s]; k++)
                            emit(names[s * MAX_NAME_D + k]);
                        repeat (ent_pad[s]) emit(8'h00);
                        dir_half = 0;
                        dir_idx++;
                    end
                    dir_size += n_out;
                    arch_len += n_out;
                end
            end
            CMD_DEND: begin
                emit_sig(8'h05, 8'h06);
                emit16(16'd0); emit16(16'd0);
                emit16(16'(n_files)); emit16(16'(n_files));
                emit32(dir_size); emit32(dir_off);
                emit16(16'd0);
                arch_len += 32'd22;
            end
            default: ;
        endcase
        if (n_out > 0) stream_q[stream_q.size() - 1].last = 1'b1;
    endfunction

    // sender: bursts of back-to-back words with random gaps between them
    int burst_left = 0;

    task automatic send_word(logic [2:0] cmd, logic [7:0] d, logic [31:0] m,
                             logic [5:0] nl, logic [5:0] al, int first = -1);
        int gap, base;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid <= 1'b1;
        i_command <= cmd; i_data_byte <= d; i_modified <= m;
        i_name_length <= nl; i_alignment <= al;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        base = stream_q.size();
        predict_archive(cmd, d, m, nl, al);
        if (first >= 0 && n_out > 0) stream_q[base].b = first[7:0];
    endtask

    // receiver stall pattern, changing mode now and then
    int stall_mode = 0, stall_cnt = 0;
    always @(posedge i_clk) begin
        stall_cnt <= stall_cnt + 1;
        if (stall_cnt % 97 == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(0, 3) == 0);
            2: i_stall <= (stall_cnt % 5 < 2);
            default: i_stall <= ($urandom_range(0, 1) == 0);
        endcase
    end

    // byte checker
    always @(posedge i_clk) begin
        t_zip_byte want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (stream_q.size() == 0) begin
                $display("%0t: unexpected byte %h last %b error %b",
                         $time, o_out_byte, o_last, o_error);
                failed = 1;
            end else begin
                want = stream_q.pop_front();
                if (o_out_byte !== want.b || o_last !== want.last || o_error !== want.err) begin
                    $display("%0t: expected byte %h last %b error %b, got %h %b %b",
                             $time, want.b, want.last, want.err,
                             o_out_byte, o_last, o_error);
                    failed = 1;
                end
            end
        end
    end

    t_stim_row dir_rows[18] = '{
        '{CMD_START, 8'h00, 32'hffffffff, 6'd0, 6'd0, 8'h50},
        '{CMD_DATA,  8'hff, 32'h0, 6'd0, 6'd0, -1},
        '{CMD_DATA,  8'h00, 32'h0, 6'd0, 6'd0, -1},
        '{CMD_END,   8'h00, 32'h0, 6'd0, 6'd0, 8'h50},
        '{CMD_END,   8'h00, 32'h0, 6'd0, 6'd0, -1},       // early end, nothing out
        '{CMD_DATA,  8'h5a, 32'h0, 6'd0, 6'd0, -1},       // stray byte while idle
        '{CMD_RSVD,        8'h00, 32'h0, 6'd0, 6'd0, -1},
        '{CMD_RSVD + 3'd1, 8'h00, 32'h0, 6'd0, 6'd0, -1},
        '{CMD_RSVD + 3'd2, 8'h00, 32'h0, 6'd0, 6'd0, -1},
        '{CMD_START, 8'h00, 32'h00000000, 6'd2, 6'd63, 8'h50},
        '{CMD_DATA,  8'h61, 32'h0, 6'd0, 6'd0, -1},
        '{CMD_DATA,  8'h62, 32'h0, 6'd0, 6'd0, -1},
        '{CMD_DATA,  8'h80, 32'h0, 6'd0, 6'd0, -1},
        '{CMD_START, 8'h00, 32'h12345678, 6'd1, 6'd7, 8'h50}, // abandons open file
        '{CMD_DATA,  8'h63, 32'h0, 6'd0, 6'd0, -1},
        '{CMD_DATA,  8'h01, 32'h0, 6'd0, 6'd0, -1},
        '{CMD_END,   8'h00, 32'h0, 6'd0, 6'd0, 8'h50},
        '{CMD_DEND,  8'h00, 32'h0, 6'd0, 6'd0, 8'h50}
    };

    task automatic send_noise();
        case ($urandom_range(0, 3))
            0: send_word(CMD_RSVD + 3'($urandom_range(0, 2)), 8'($urandom), $urandom,
                         6'($urandom), 6'($urandom));
            1: send_word(CMD_END, 8'($urandom), $urandom, 6'($urandom), 6'($urandom));
            2: send_word(CMD_DATA, 8'($urandom), $urandom, 6'($urandom), 6'($urandom));
            default: send_word(CMD_DEND, 8'($urandom), $urandom, 6'($urandom),
                               6'($urandom));
        endcase
    endtask

    initial begin
        int nl, nc, pick;
        arch_len = '0; cur_crc = '1; file_len = '0; dir_off = '0; dir_size = '0;
        n_files = 0; name_idx = 0; dir_idx = 0; dir_half = 0; ph = PH_IDLE;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k])
            send_word(dir_rows[k].cmd, dir_rows[k].data, dir_rows[k].modified,
                      dir_rows[k].nl, dir_rows[k].al, dir_rows[k].first);

        // random files until the table fills
        while (n_files < MAX_FILES_D) begin
            pick = $urandom_range(0, 19);
            nl = (pick == 0) ? $urandom_range(32, 63) : $urandom_range(0, 4);
            send_word(CMD_START, 8'($urandom), $urandom, 6'(nl),
                      6'(($urandom_range(0, 1)) ? $urandom_range(0, 63)
                                                : $urandom_range(0, 8)));
            if (ph == PH_NAME && $urandom_range(0, 4) == 0) send_noise();
            while (ph == PH_NAME)
                send_word(CMD_DATA, 8'($urandom), $urandom, 6'($urandom), 6'($urandom));
            nc = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 12) : $urandom_range(0, 4);
            repeat (nc) begin
                if ($urandom_range(0, 9) == 0)
                    send_word(CMD_RSVD + 3'($urandom_range(0, 2)), 8'($urandom),
                              $urandom, 6'($urandom), 6'($urandom));
                send_word(CMD_DATA, 8'($urandom), $urandom, 6'($urandom), 6'($urandom));
            end
            // now and then the next start abandons this file
            if ($urandom_range(0, 5) != 0)
                send_word(CMD_END, 8'($urandom), $urandom, 6'($urandom), 6'($urandom));
            if ($urandom_range(0, 4) == 0 && ph == PH_IDLE) send_noise();
        end
        if (ph == PH_CONTENT)
            send_word(CMD_END, 8'h00, 32'h0, 6'd0, 6'd0);

        // table full: start is rejected
        repeat (3)
            send_word(CMD_START, 8'($urandom), $urandom, 6'($urandom), 6'($urandom));

        repeat (2 * MAX_FILES_D + 1)
            send_word(CMD_DIR, 8'($urandom), $urandom, 6'($urandom), 6'($urandom));
        send_word(CMD_DEND, 8'($urandom), $urandom, 6'($urandom), 6'($urandom));
        i_valid <= 1'b0;

        while (stream_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (!failed && stream_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #3_000_000;
        $display("Test completed with failures");
        $finish;
    end
endmodule
